[sv/assert_macros.svh]
// Assertion macros used by the checker file of the register block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("register block assertion failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("register block assertion failed");

`endif

[sv/hiorb_pkg.sv]
// Package of the handheld I/O register block: bus addresses, widths,
// memory geometry and stream field positions. No dependencies.
package hiorb_pkg;

   localparam int DATA_W      = 8;
   localparam int BUS_ADDR_W  = 16;
   localparam int ROM_ADDR_W  = 18;
   localparam int OFFSET_W    = 10;
   localparam int SIZE_MODE_W = 2;

   // Bus addresses that do something.
   localparam logic [BUS_ADDR_W-1:0] ADDR_HWREV  = 16'hFC88;
   localparam logic [BUS_ADDR_W-1:0] ADDR_IODAT  = 16'hFD8B;
   localparam logic [BUS_ADDR_W-1:0] ADDR_SYSCTL = 16'hFD87;
   localparam logic [BUS_ADDR_W-1:0] ADDR_CART   = 16'hFCB2;
   localparam logic [BUS_ADDR_W-1:0] ADDR_PAL_LO = 16'hFDA0;
   localparam logic [BUS_ADDR_W-1:0] ADDR_PAL_HI = 16'hFDBF;
   localparam logic [BUS_ADDR_W-1:0] ADDR_BASE_H = 16'hFD95;
   localparam logic [BUS_ADDR_W-1:0] ADDR_BASE_L = 16'hFD94;
   localparam logic [BUS_ADDR_W-1:0] ADDR_SPR_LO = 16'hFC00;
   localparam logic [BUS_ADDR_W-1:0] ADDR_SPR_HI = 16'hFC7F;
   localparam logic [BUS_ADDR_W-1:0] ADDR_DRAW   = 16'hFC91;
   localparam logic [BUS_ADDR_W-1:0] ADDR_DCTL   = 16'hFD92;

   localparam logic [DATA_W-1:0] HW_VERSION = 8'd1;

   // Cartridge page size codes; any other code acts as the largest page.
   localparam logic [SIZE_MODE_W-1:0] SIZE_256 = 2'd0;
   localparam logic [SIZE_MODE_W-1:0] SIZE_512 = 2'd1;

   // Memory geometry. The sprite file is split into even and odd byte halves.
   localparam int PAL_DEPTH = 32;
   localparam int SPR_DEPTH = 64;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_SIZE = 1'b0;

   // Stream payload layout.
   localparam int REQ_TDATA_W  = 24;
   localparam int RSP_TDATA_W  = 56;
   localparam int RSP_READ_LSB = 0;
   localparam int RSP_ROMA_LSB = 8;
   localparam int RSP_DRAW_BIT = 26;
   localparam int RSP_BASE_LSB = 27;
   localparam int RSP_CTL_LSB  = 43;
   localparam int RSP_PAD_W    = 5;

endpackage

[sv/hiorb_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// A read at the address being written returns the old contents.
// No dependencies.
module hiorb_ram #(
   parameter int Width = 8,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/handheld_io_register_block_unit.sv]
// Top level of the handheld I/O register block.
// Depends on hiorb_pkg and hiorb_ram.
//
// Usage:
// The req channel carries one bus access per beat: req_tuser is the access
// kind (0 read, 1 write), req_tdata holds the address and the write byte.
// The rsp channel returns exactly one beat per access, in order: the read
// byte, the ROM fetch flag and address for cartridge reads, the draw start
// pulse, and the display base and control values as they stand after the
// access. The csr port (APB style, always ready) holds the cartridge page
// size at byte address 0.
// An accepted req beat reaches rsp_tvalid through the registered read of the
// palette and sprite memories, then through the output register. With
// rsp_tready high one access is taken every cycle; the memories are written
// at the accept edge, so a read right after a write to the same byte already
// sees the new value.
// When the receiver stalls, the output register and the memory read stage
// hold their beats and req_tready drops once both are full.
// Reset clears the control state and the valid bits of every memory entry,
// so palette and sprite bytes read as zero until written; no clearing pass.
module handheld_io_register_block_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   // req_tdata: address [15:0], write_data [23:16]
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [hiorb_pkg::REQ_TDATA_W-1:0]        req_tdata,
   // req_tuser: op [0]
   input  logic                                     req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // rsp_tdata: read_data [7:0], rom_address [25:8], draw_start [26],
   // display_base [42:27], display_control [50:43], zero fill [55:51]
   output logic [hiorb_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   // rsp_tuser: rom_fetch [0]
   output logic                                     rsp_tuser,
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [hiorb_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [hiorb_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [hiorb_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                     csr_pready
);

   localparam int DW      = hiorb_pkg::DATA_W;
   localparam int PAL_AW  = $clog2(hiorb_pkg::PAL_DEPTH);
   localparam int SPR_AW  = $clog2(hiorb_pkg::SPR_DEPTH);
   localparam int OFS_W   = hiorb_pkg::OFFSET_W;
   localparam int ROMA_W  = hiorb_pkg::ROM_ADDR_W;
   localparam int MODE_W  = hiorb_pkg::SIZE_MODE_W;

   // Where the read byte of a beat comes from.
   typedef enum logic [2:0] {
      SRC_NONE,
      SRC_HWREV,
      SRC_PAL,
      SRC_SPR_LO,
      SRC_SPR_HI
   } rd_src_type;

   // Everything of a beat that waits for the memory read data.
   typedef struct packed {
      rd_src_type          src;
      logic                hit;
      logic                fetch;
      logic [ROMA_W-1:0]   rom_addr;
      logic                draw;
      logic [15:0]         base;
      logic [DW-1:0]       ctl;
   } mem_stage_type;

   // ---------------------------------------------------------------------
   // Configuration register.
   // ---------------------------------------------------------------------
   logic [MODE_W-1:0] size_mode_ff, size_mode_in;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      size_mode_in = size_mode_ff;
      if (csr_wr && csr_paddr[2] == hiorb_pkg::CSR_IDX_SIZE) begin
         size_mode_in = csr_pwdata[MODE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == hiorb_pkg::CSR_IDX_SIZE) begin
         csr_prdata = {{(hiorb_pkg::CSR_DATA_W-MODE_W){1'b0}}, size_mode_ff};
      end
   end

   // ---------------------------------------------------------------------
   // Handshake and pipeline control.
   // ---------------------------------------------------------------------
   logic          s1_vld_ff, s1_vld_in;
   mem_stage_type s1_ff, s1_in;
   logic          rsp_vld_ff, rsp_vld_in;
   logic [hiorb_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic          rsp_user_ff, rsp_user_in;
   logic          out_free, s1_move, acc;

   assign out_free   = ~rsp_vld_ff | rsp_tready;
   assign s1_move    = s1_vld_ff & out_free;
   assign req_tready = ~s1_vld_ff | out_free;
   assign acc        = req_tvalid & req_tready;

   // ---------------------------------------------------------------------
   // Address decode of the incoming beat.
   // ---------------------------------------------------------------------
   logic              is_wr;
   logic [15:0]       addr;
   logic [DW-1:0]     wdata;
   logic              in_pal, in_spr;

   assign is_wr  = req_tuser;
   assign addr   = req_tdata[15:0];
   assign wdata  = req_tdata[23:16];
   assign in_pal = (addr >= hiorb_pkg::ADDR_PAL_LO) && (addr <= hiorb_pkg::ADDR_PAL_HI);
   assign in_spr = (addr >= hiorb_pkg::ADDR_SPR_LO) && (addr <= hiorb_pkg::ADDR_SPR_HI);

   logic [PAL_AW-1:0] pal_idx;
   logic [SPR_AW-1:0] spr_idx;

   assign pal_idx = addr[PAL_AW-1:0];
   assign spr_idx = addr[SPR_AW:1];

   // ---------------------------------------------------------------------
   // Memories. Writes land at the accept edge; the sprite file keeps even
   // bytes and odd bytes apart so that a write to an even byte can clear
   // its odd partner in the same cycle.
   // ---------------------------------------------------------------------
   logic          pal_we, spr_lo_we, spr_hi_we;
   logic [DW-1:0] spr_hi_wdata;
   logic [DW-1:0] pal_q, spr_lo_q, spr_hi_q;

   assign pal_we       = acc & is_wr & in_pal;
   assign spr_lo_we    = acc & is_wr & in_spr & ~addr[0];
   assign spr_hi_we    = acc & is_wr & in_spr;
   assign spr_hi_wdata = addr[0] ? wdata : '0;

   hiorb_ram #(.Width(DW), .Depth(hiorb_pkg::PAL_DEPTH)) u_pal_ram (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (pal_idx),
      .wr_data (wdata),
      .rd_en   (acc),
      .rd_addr (pal_idx),
      .rd_data (pal_q)
   );

   hiorb_ram #(.Width(DW), .Depth(hiorb_pkg::SPR_DEPTH)) u_spr_lo_ram (
      .clock   (clock),
      .wr_en   (spr_lo_we),
      .wr_addr (spr_idx),
      .wr_data (wdata),
      .rd_en   (acc),
      .rd_addr (spr_idx),
      .rd_data (spr_lo_q)
   );

   hiorb_ram #(.Width(DW), .Depth(hiorb_pkg::SPR_DEPTH)) u_spr_hi_ram (
      .clock   (clock),
      .wr_en   (spr_hi_we),
      .wr_addr (spr_idx),
      .wr_data (spr_hi_wdata),
      .rd_en   (acc),
      .rd_addr (spr_idx),
      .rd_data (spr_hi_q)
   );

   // An entry that was never written since reset reads as zero.
   logic [hiorb_pkg::PAL_DEPTH-1:0] pal_vld_ff, pal_vld_in;
   logic [hiorb_pkg::SPR_DEPTH-1:0] spr_lo_vld_ff, spr_lo_vld_in;
   logic [hiorb_pkg::SPR_DEPTH-1:0] spr_hi_vld_ff, spr_hi_vld_in;

   always_comb begin
      pal_vld_in    = pal_vld_ff;
      spr_lo_vld_in = spr_lo_vld_ff;
      spr_hi_vld_in = spr_hi_vld_ff;
      if (pal_we) begin
         pal_vld_in[pal_idx] = 1'b1;
      end
      if (spr_lo_we) begin
         spr_lo_vld_in[spr_idx] = 1'b1;
      end
      if (spr_hi_we) begin
         spr_hi_vld_in[spr_idx] = 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Cartridge and display registers, updated at the accept edge.
   // ---------------------------------------------------------------------
   logic [DW-1:0]    block_ff, block_in;
   logic [OFS_W-1:0] offset_ff, offset_in;
   logic [DW-1:0]    latch_ff, latch_in;
   logic             strobe_ff, strobe_in;
   logic [15:0]      base_ff, base_in;
   logic [DW-1:0]    ctl_ff, ctl_in;
   logic [ROMA_W-1:0] rom_addr;

   // ROM byte address from the current block and the offset before it counts.
   always_comb begin
      case (size_mode_ff)
         hiorb_pkg::SIZE_256: rom_addr = {2'b00, block_ff, offset_ff[7:0]};
         hiorb_pkg::SIZE_512: rom_addr = {1'b0, block_ff, offset_ff[8:0]};
         default:             rom_addr = {block_ff, offset_ff};
      endcase
   end

   always_comb begin
      block_in  = block_ff;
      offset_in = offset_ff;
      latch_in  = latch_ff;
      strobe_in = strobe_ff;
      base_in   = base_ff;
      ctl_in    = ctl_ff;
      if (acc) begin
         if (!is_wr) begin
            if (addr == hiorb_pkg::ADDR_CART) begin
               offset_in = offset_ff + OFS_W'(1);
            end
         end else begin
            if (addr == hiorb_pkg::ADDR_IODAT) begin
               latch_in = wdata;
            end else if (addr == hiorb_pkg::ADDR_SYSCTL) begin
               // The block register shifts on a falling strobe; writing a low strobe
               // clears the page offset.
               if (strobe_ff && !wdata[0]) begin
                  block_in = {block_ff[DW-2:0], latch_ff[1]};
               end
               if (!wdata[0]) begin
                  offset_in = '0;
               end
               strobe_in = wdata[0];
            end else if (addr == hiorb_pkg::ADDR_BASE_H) begin
               base_in = {wdata, base_ff[7:0]};
            end else if (addr == hiorb_pkg::ADDR_BASE_L) begin
               base_in = {base_ff[15:8], wdata};
            end else if (addr == hiorb_pkg::ADDR_DCTL) begin
               ctl_in = wdata;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Memory read stage.
   // ---------------------------------------------------------------------
   always_comb begin
      s1_in          = s1_ff;
      s1_in.src      = SRC_NONE;
      s1_in.hit      = 1'b0;
      s1_in.fetch    = 1'b0;
      s1_in.rom_addr = '0;
      s1_in.draw     = 1'b0;
      s1_in.base     = base_in;
      s1_in.ctl      = ctl_in;
      if (!is_wr) begin
         if (in_pal) begin
            s1_in.src = SRC_PAL;
            s1_in.hit = pal_vld_ff[pal_idx];
         end else if (addr == hiorb_pkg::ADDR_HWREV) begin
            s1_in.src = SRC_HWREV;
         end else if (addr == hiorb_pkg::ADDR_CART) begin
            s1_in.fetch    = 1'b1;
            s1_in.rom_addr = rom_addr;
         end else if (in_spr) begin
            if (addr[0]) begin
               s1_in.src = SRC_SPR_HI;
               s1_in.hit = spr_hi_vld_ff[spr_idx];
            end else begin
               s1_in.src = SRC_SPR_LO;
               s1_in.hit = spr_lo_vld_ff[spr_idx];
            end
         end
      end else if (addr == hiorb_pkg::ADDR_DRAW) begin
         s1_in.draw = wdata[0];
      end
      if (!acc) begin
         s1_in = s1_ff;
      end
   end

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (acc) begin
         s1_vld_in = 1'b1;
      end else if (s1_move) begin
         s1_vld_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Output register.
   // ---------------------------------------------------------------------
   logic [DW-1:0] rd_byte;

   always_comb begin
      case (s1_ff.src)
         SRC_HWREV:  rd_byte = hiorb_pkg::HW_VERSION;
         SRC_PAL:    rd_byte = s1_ff.hit ? pal_q : '0;
         SRC_SPR_LO: rd_byte = s1_ff.hit ? spr_lo_q : '0;
         SRC_SPR_HI: rd_byte = s1_ff.hit ? spr_hi_q : '0;
         default:    rd_byte = '0;
      endcase
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_vld_in  = rsp_vld_ff;
      if (s1_move) begin
         rsp_data_in = {{hiorb_pkg::RSP_PAD_W{1'b0}}, s1_ff.ctl, s1_ff.base,
                        s1_ff.draw, s1_ff.rom_addr, rd_byte};
         rsp_user_in = s1_ff.fetch;
         rsp_vld_in  = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in  = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ---------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         size_mode_ff  <= '0;
         s1_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         pal_vld_ff    <= '0;
         spr_lo_vld_ff <= '0;
         spr_hi_vld_ff <= '0;
         block_ff      <= '0;
         offset_ff     <= '0;
         latch_ff      <= '0;
         strobe_ff     <= 1'b0;
         base_ff       <= '0;
         ctl_ff        <= '0;
      end else begin
         size_mode_ff  <= size_mode_in;
         s1_vld_ff     <= s1_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
         pal_vld_ff    <= pal_vld_in;
         spr_lo_vld_ff <= spr_lo_vld_in;
         spr_hi_vld_ff <= spr_hi_vld_in;
         block_ff      <= block_in;
         offset_ff     <= offset_in;
         latch_ff      <= latch_in;
         strobe_ff     <= strobe_in;
         base_ff       <= base_in;
         ctl_ff        <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

[sv/hiorb_checker.sv]
// Port-level checker for the handheld I/O register block, bound to the top.
// Depends on hiorb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hiorb_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [hiorb_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                               rsp_tuser
);

   logic [hiorb_pkg::DATA_W-1:0]     rd_byte;
   logic [hiorb_pkg::ROM_ADDR_W-1:0] rom_addr;
   logic                             draw;

   assign rd_byte  = rsp_tdata[hiorb_pkg::RSP_READ_LSB +: hiorb_pkg::DATA_W];
   assign rom_addr = rsp_tdata[hiorb_pkg::RSP_ROMA_LSB +: hiorb_pkg::ROM_ADDR_W];
   assign draw     = rsp_tdata[hiorb_pkg::RSP_DRAW_BIT];

   // A cartridge fetch carries no register byte.
   `ASSERT_IMPLY(a_fetch_no_byte, clock, reset, rsp_tvalid && rsp_tuser, rd_byte == '0)
   // The ROM address is only given out with a fetch.
   `ASSERT_IMPLY(a_addr_only_on_fetch, clock, reset, rsp_tvalid && !rsp_tuser, rom_addr == '0)
   // Draw start comes from a write, a fetch from a read.
   `ASSERT_IMPLY(a_draw_not_fetch, clock, reset, rsp_tvalid && draw, !rsp_tuser)
   // A stalled result beat stays offered.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // Nothing is offered in the cycle after a reset edge.
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind handheld_io_register_block_unit hiorb_checker u_hiorb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[sim/testbench.sv]
// Self-checking testbench for handheld_io_register_block_unit: random and directed bus
// accesses on the req stream, each rsp beat checked against an in-bench predictor.
// Depends on hiorb_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench;

   // Widths taken from the package.
   localparam int DATA_W      = hiorb_pkg::DATA_W;
   localparam int ROM_ADDR_W  = hiorb_pkg::ROM_ADDR_W;
   localparam int OFFSET_W    = hiorb_pkg::OFFSET_W;
   localparam int SIZE_MODE_W = hiorb_pkg::SIZE_MODE_W;
   localparam int CSR_ADDR_W  = hiorb_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W  = hiorb_pkg::CSR_DATA_W;
   localparam int REQ_TDATA_W = hiorb_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = hiorb_pkg::RSP_TDATA_W;

   // Access kinds as they travel on req_tuser.
   typedef enum logic {OP_READ = 1'b0, OP_WRITE = 1'b1} bus_op_type;

   // Page size codes beyond the two that the package names. The top code is
   // not a real size; the block treats it as the largest page.
   localparam logic [SIZE_MODE_W-1:0] SIZE_1024      = 2'd2;
   localparam logic [SIZE_MODE_W-1:0] SIZE_SATURATED = 2'd3;

   // Byte address of the page size register on the csr port.
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_SIZE =
      CSR_ADDR_W'(4 * hiorb_pkg::CSR_IDX_SIZE);

   // How long the receiver holds off in the back-pressure test, in cycles.
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int MISMATCH_PRINT_LIMIT = 10;

   // One response beat, split into its fields.
   typedef struct packed {
      logic [DATA_W-1:0]     read_data;
      logic                  rom_fetch;
      logic [ROM_ADDR_W-1:0] rom_address;
      logic                  draw_start;
      logic [15:0]           display_base;
      logic [7:0]            display_control;
   } bus_response_type;

   // Tracks the register state the block should hold, predicts the response
   // of every accepted access, and matches responses against them in order.
   class io_access_tracker;
      logic [DATA_W-1:0]      palette [hiorb_pkg::PAL_DEPTH];
      logic [DATA_W-1:0]      sprite_bytes [2 * hiorb_pkg::SPR_DEPTH];
      logic [7:0]             bank_shift;
      logic [OFFSET_W-1:0]    page_ofs;
      logic [7:0]             cart_latch;
      logic                   strobe_lvl;
      logic [15:0]            frame_base;
      logic [7:0]             display_ctl;
      logic [SIZE_MODE_W-1:0] size_mode;
      bus_response_type       expected_responses[$];
      int                     failures;

      function new();
         foreach (palette[i]) palette[i] = '0;
         foreach (sprite_bytes[i]) sprite_bytes[i] = '0;
         bank_shift  = '0;
         page_ofs    = '0;
         cart_latch  = '0;
         strobe_lvl  = 1'b0;
         frame_base  = '0;
         display_ctl = '0;
         size_mode   = hiorb_pkg::SIZE_256;
         failures    = 0;
      endfunction

      function void set_size_mode(logic [SIZE_MODE_W-1:0] mode);
         size_mode = mode;
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= MISMATCH_PRINT_LIMIT) $display("%0t ns: %s", $realtime, msg);
      endfunction

      function void note_access(bus_op_type op, logic [15:0] addr, logic [7:0] wdata);
         bus_response_type      rsp;
         int unsigned           page_bits;
         logic [ROM_ADDR_W-1:0] page_mask;
         rsp = '0;
         if (op == OP_READ) begin
            if (addr >= hiorb_pkg::ADDR_PAL_LO && addr <= hiorb_pkg::ADDR_PAL_HI) begin
               rsp.read_data = palette[addr[4:0]];
            end else if (addr == hiorb_pkg::ADDR_HWREV) begin
               rsp.read_data = hiorb_pkg::HW_VERSION;
            end else if (addr == hiorb_pkg::ADDR_CART) begin
               // The address is formed from the offset before it counts up.
               page_bits = (size_mode == hiorb_pkg::SIZE_256) ? 8 :
                           (size_mode == hiorb_pkg::SIZE_512) ? 9 : 10;
               page_mask = (ROM_ADDR_W'(1) << page_bits) - ROM_ADDR_W'(1);
               rsp.rom_fetch   = 1'b1;
               rsp.rom_address = (ROM_ADDR_W'(bank_shift) << page_bits)
                                 | (ROM_ADDR_W'(page_ofs) & page_mask);
               page_ofs = page_ofs + 1'b1;
            end else if (addr >= hiorb_pkg::ADDR_SPR_LO && addr <= hiorb_pkg::ADDR_SPR_HI) begin
               rsp.read_data = sprite_bytes[addr[6:0]];
            end
         end else begin
            if (addr == hiorb_pkg::ADDR_IODAT) begin
               cart_latch = wdata;
            end else if (addr == hiorb_pkg::ADDR_SYSCTL) begin
               // A falling strobe shifts in latch bit 1; a low strobe clears the offset.
               if (strobe_lvl && !wdata[0]) bank_shift = {bank_shift[6:0], cart_latch[1]};
               if (!wdata[0]) page_ofs = '0;
               strobe_lvl = wdata[0];
            end else if (addr >= hiorb_pkg::ADDR_PAL_LO && addr <= hiorb_pkg::ADDR_PAL_HI) begin
               palette[addr[4:0]] = wdata;
            end else if (addr == hiorb_pkg::ADDR_BASE_H) begin
               frame_base[15:8] = wdata;
            end else if (addr == hiorb_pkg::ADDR_BASE_L) begin
               frame_base[7:0] = wdata;
            end else if (addr == hiorb_pkg::ADDR_DCTL) begin
               display_ctl = wdata;
            end else if (addr >= hiorb_pkg::ADDR_SPR_LO && addr <= hiorb_pkg::ADDR_SPR_HI) begin
               sprite_bytes[addr[6:0]] = wdata;
               if (!addr[0]) sprite_bytes[{addr[6:1], 1'b1}] = '0;
            end else if (addr == hiorb_pkg::ADDR_DRAW) begin
               rsp.draw_start = wdata[0];
            end
         end
         rsp.display_base    = frame_base;
         rsp.display_control = display_ctl;
         expected_responses.push_back(rsp);
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] tdata, logic tuser);
         bus_response_type got, exp;
         got.read_data       = tdata[hiorb_pkg::RSP_READ_LSB +: DATA_W];
         got.rom_fetch       = tuser;
         got.rom_address     = tdata[hiorb_pkg::RSP_ROMA_LSB +: ROM_ADDR_W];
         got.draw_start      = tdata[hiorb_pkg::RSP_DRAW_BIT];
         got.display_base    = tdata[hiorb_pkg::RSP_BASE_LSB +: 16];
         got.display_control = tdata[hiorb_pkg::RSP_CTL_LSB +: 8];
         if (expected_responses.size() == 0) begin
            report($sformatf("response beat with nothing outstanding: rd=%02h fetch=%0b",
                             got.read_data, got.rom_fetch));
            return;
         end
         exp = expected_responses.pop_front();
         if (got.read_data !== exp.read_data || got.rom_fetch !== exp.rom_fetch
             || got.rom_address !== exp.rom_address || got.draw_start !== exp.draw_start
             || got.display_base !== exp.display_base
             || got.display_control !== exp.display_control) begin
            report($sformatf({"response mismatch: expected rd=%02h fetch=%0b rom=%05h ",
                              "draw=%0b base=%04h ctl=%02h, got rd=%02h fetch=%0b ",
                              "rom=%05h draw=%0b base=%04h ctl=%02h"},
                             exp.read_data, exp.rom_fetch, exp.rom_address, exp.draw_start,
                             exp.display_base, exp.display_control,
                             got.read_data, got.rom_fetch, got.rom_address, got.draw_start,
                             got.display_base, got.display_control));
         end
      endfunction
   endclass

   // Every input starts at a known value; reset is high from time zero.
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                    req_tuser = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   io_access_tracker tracker = new();

   // Shared knobs between the stimulus and the receiver. no_gaps turns off
   // idling on both sides; hold_rsp asks the receiver for one long hold-off.
   bit no_gaps  = 1'b0;
   bit hold_rsp = 1'b0;
   int accesses_sent = 0;

   handheld_io_register_block_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs. Even with the longest idles on both
   // sides for every beat, a correct run stays several times under this.
   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (no_gaps) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Both channels are sampled at the clock edge. The response is checked
   // before the new request is noted so the order never depends on the
   // scheduler; the block cannot answer an access at the edge that takes it.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_response(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready)
            tracker.note_access(bus_op_type'(req_tuser), req_tdata[15:0], req_tdata[23:16]);
      end
   end

   // Receiver: runs of ready cycles broken by stalls, plus one long hold-off
   // on request so that the block fills up and stops taking beats.
   initial begin : rsp_sink
      int run_len;
      int stall_len;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         run_len = $urandom_range(1, 20);
         rsp_tready <= 1'b1;
         repeat (run_len) @(posedge clock);
         stall_len = pick_gap();
         if (stall_len > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   // Offers one access after a random gap and returns at the edge that takes
   // it. tvalid stays high so a following beat can go out back to back.
   task automatic send_access(bus_op_type op, logic [15:0] addr, logic [7:0] wdata);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {wdata, addr};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      accesses_sent++;
   endtask

   // Stops offering and waits until every predicted response has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.pending() > 0);
   endtask

   // Writes the page size register, reads it back, and updates the predictor.
   // Only called with the block idle.
   task automatic set_page_size(logic [SIZE_MODE_W-1:0] mode);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_SIZE;
      csr_pwdata  <= CSR_DATA_W'(mode);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_size_mode(mode);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(mode))
         tracker.report($sformatf("page size readback: expected %0d, got %0h", mode, csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // The well-formed cartridge sequence: clock a few bits into the block
   // register through latch and strobe, then stream some ROM reads.
   task automatic load_rom_bank(int bits, int reads);
      logic [7:0] strobe_byte;
      repeat (bits) begin
         send_access(OP_WRITE, hiorb_pkg::ADDR_IODAT, 8'($urandom));
         strobe_byte = 8'($urandom) | 8'h01;
         send_access(OP_WRITE, hiorb_pkg::ADDR_SYSCTL, strobe_byte);
         strobe_byte = 8'($urandom) & 8'hFE;
         send_access(OP_WRITE, hiorb_pkg::ADDR_SYSCTL, strobe_byte);
      end
      repeat (reads) send_access(OP_READ, hiorb_pkg::ADDR_CART, 8'($urandom));
   endtask

   // One random access or short sequence. Most traffic hits the registers
   // that do something; the rest is anywhere in the address space.
   task automatic random_access();
      int         roll;
      bus_op_type op;
      logic [7:0] wdata;
      roll  = $urandom_range(0, 99);
      op    = bus_op_type'($urandom_range(0, 1));
      wdata = 8'($urandom);
      if (roll < 18)
         send_access(op, hiorb_pkg::ADDR_SPR_LO
                         + 16'($urandom_range(0, 2 * hiorb_pkg::SPR_DEPTH - 1)), wdata);
      else if (roll < 30)
         send_access(op, hiorb_pkg::ADDR_PAL_LO
                         + 16'($urandom_range(0, hiorb_pkg::PAL_DEPTH - 1)), wdata);
      else if (roll < 40)
         send_access(OP_READ, hiorb_pkg::ADDR_CART, wdata);
      else if (roll < 43)
         load_rom_bank($urandom_range(1, 8), $urandom_range(1, 12));
      else if (roll < 48)
         send_access(op, hiorb_pkg::ADDR_SYSCTL, wdata);
      else if (roll < 52)
         send_access(op, hiorb_pkg::ADDR_IODAT, wdata);
      else if (roll < 58)
         send_access(op, ($urandom_range(0, 1) != 0) ? hiorb_pkg::ADDR_BASE_H
                                                     : hiorb_pkg::ADDR_BASE_L, wdata);
      else if (roll < 62)
         send_access(op, hiorb_pkg::ADDR_DCTL, wdata);
      else if (roll < 67)
         send_access(op, hiorb_pkg::ADDR_DRAW, wdata);
      else if (roll < 70)
         send_access(op, hiorb_pkg::ADDR_HWREV, wdata);
      else if (roll < 85)
         send_access(op, hiorb_pkg::ADDR_SPR_LO + 16'($urandom_range(0, 16'h01FF)), wdata);
      else
         send_access(op, 16'($urandom), wdata);
   endtask

   task automatic run_random(int count);
      int target;
      target = accesses_sent + count;
      while (accesses_sent < target) random_access();
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The register resets to the smallest page, but write it anyway.
      set_page_size(hiorb_pkg::SIZE_256);

      // Directed part: field extremes, every register, and the corner cases.
      send_access(OP_READ,  hiorb_pkg::ADDR_HWREV,  8'h00);
      send_access(OP_WRITE, hiorb_pkg::ADDR_PAL_LO, 8'hFF);
      send_access(OP_READ,  hiorb_pkg::ADDR_PAL_LO, 8'h00);
      send_access(OP_WRITE, hiorb_pkg::ADDR_PAL_HI, 8'hA5);
      send_access(OP_READ,  hiorb_pkg::ADDR_PAL_HI, 8'hFF);
      // A write to the odd byte sticks until its even partner is written.
      send_access(OP_WRITE, hiorb_pkg::ADDR_SPR_HI, 8'hFF);
      send_access(OP_READ,  hiorb_pkg::ADDR_SPR_HI, 8'h00);
      send_access(OP_WRITE, hiorb_pkg::ADDR_SPR_HI - 16'd1, 8'h00);
      send_access(OP_READ,  hiorb_pkg::ADDR_SPR_HI, 8'h00);
      send_access(OP_WRITE, hiorb_pkg::ADDR_SPR_LO, 8'hFF);
      send_access(OP_READ,  hiorb_pkg::ADDR_SPR_LO, 8'h00);
      send_access(OP_WRITE, hiorb_pkg::ADDR_BASE_H, 8'hFF);
      send_access(OP_WRITE, hiorb_pkg::ADDR_BASE_L, 8'h00);
      send_access(OP_WRITE, hiorb_pkg::ADDR_DCTL,   8'hFF);
      send_access(OP_WRITE, hiorb_pkg::ADDR_DRAW,   8'h01);
      send_access(OP_WRITE, hiorb_pkg::ADDR_DRAW,   8'hFE);
      // Strobe high then low shifts latch bit 1 into the block and clears
      // the offset; the cart reads then walk the page.
      send_access(OP_WRITE, hiorb_pkg::ADDR_IODAT,  8'hFF);
      send_access(OP_WRITE, hiorb_pkg::ADDR_SYSCTL, 8'h01);
      send_access(OP_WRITE, hiorb_pkg::ADDR_SYSCTL, 8'hFE);
      send_access(OP_READ,  hiorb_pkg::ADDR_CART,   8'hFF);
      send_access(OP_READ,  hiorb_pkg::ADDR_CART,   8'h00);
      // Unknown addresses: the keypad and both ends of the address space.
      send_access(OP_READ,  16'hFCB0,    8'h00);
      send_access(OP_READ,  16'h0000,    8'h00);
      send_access(OP_WRITE, 16'hFFFF,    8'hFF);
      send_access(OP_READ,  16'hFFFF,    8'h00);
      wait_drained();

      // The unused top code must act as the largest page. A full block load
      // followed by more reads than a page holds wraps the offset counter.
      set_page_size(SIZE_SATURATED);
      load_rom_bank(8, 1030);
      run_random(15);

      // Back-pressure: the receiver holds off while the sender keeps going
      // flat out, so the block fills up and drops req_tready.
      no_gaps  = 1'b1;
      hold_rsp = 1'b1;
      repeat (40) random_access();
      no_gaps  = 1'b0;
      run_random(10);
      wait_drained();

      // Medium page, with a stretch where neither side idles.
      set_page_size(hiorb_pkg::SIZE_512);
      no_gaps = 1'b1;
      run_random(15);
      no_gaps = 1'b0;
      run_random(15);
      wait_drained();

      // Largest page. In the middle the sender pauses until all responses
      // are back, then carries on.
      set_page_size(SIZE_1024);
      run_random(10);
      wait_drained();
      run_random(10);
      wait_drained();

      // Back to the smallest page to close out.
      set_page_size(hiorb_pkg::SIZE_256);
      run_random(15);
      wait_drained();

      // Let the pipeline settle so a stray extra beat would still be caught.
      repeat (8) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/hiorb_pkg.sv
sv/hiorb_ram.sv
sv/handheld_io_register_block_unit.sv
sv/hiorb_checker.sv
sim/testbench.sv
